FILE: design/sws_pkg.sv
package sws_pkg;

  // Fixed widths of the request and result fields.
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 32;

  // Request codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_FIND = 2'd3
  } action_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

FILE: design/sws_stack_ram.sv
module sws_stack_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/stack_with_search.sv
// Last-in first-out stack of words with a linear search.
// A request on the in_ channel carries an action (push, pop, peek, find) and
// a value. Every request yields exactly one result on the out_ channel with
// top_value, found and status. Both channels use valid/ready handshakes.
// Push and pop go from acceptance through S_RESP into the output register;
// peek passes first through S_PEEK, which takes the registered read data of
// the entry memory, then S_RESP. The next request is taken once the result
// is loaded, so a request is not accepted before the last one is through.
// Find reads the stack from the top down, one entry per cycle through the
// single read port of the entry memory, then passes through S_RESP. The
// number of entries examined is at most the current fill, which is at most
// STACK_DEPTH. A find on an empty stack reads no entry and goes straight to
// S_RESP.
// A new request is taken once the previous result sits in the output
// register, even if the receiver has not yet taken it. While the receiver
// stalls with a result still held, a finished result waits in the block
// and no further request is accepted.
// Reset (rst_n low, synchronous) empties the stack and the output register.
// Entry memory contents are not cleared; only entries below the fill count
// are ever read.
module stack_with_search #(
  parameter int STACK_DEPTH = 256,
  parameter int WORD_WIDTH  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sws_pkg::ACTION_W-1:0]      in_action,
  input  logic signed [sws_pkg::FIELD_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sws_pkg::FIELD_W-1:0] out_top_value,
  output logic                              out_found,
  output logic [sws_pkg::STATUS_W-1:0]      out_status
);

  import sws_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEEK,
    S_SCAN,
    S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         scan_idx_r, scan_idx_nxt;
  logic [WORD_WIDTH-1:0] key_r, key_nxt;
  logic [FIELD_W-1:0]    res_top_r, res_top_nxt;
  logic                  res_found_r, res_found_nxt;
  status_t               res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]    out_top_r, out_top_nxt;
  logic                  out_found_r, out_found_nxt;
  status_t               out_status_r, out_status_nxt;

  logic                  accept;
  logic [CW-1:0]         count_m1;
  logic [WORD_WIDTH-1:0] key_in;
  logic [FIELD_W-1:0]    rd_top;
  logic                  ram_wr_en;
  logic                  ram_rd_en;
  logic [AW-1:0]         ram_rd_addr;
  logic [WORD_WIDTH-1:0] ram_rd_data;

  // Fit the request value to the stored word width, and a stored word back
  // to the result field.
  generate
    if (WORD_WIDTH >= FIELD_W) begin : g_wide
      assign key_in = WORD_WIDTH'($unsigned(in_value));
      assign rd_top = ram_rd_data[FIELD_W-1:0];
    end else begin : g_narrow
      assign key_in = in_value[WORD_WIDTH-1:0];
      assign rd_top = {{(FIELD_W - WORD_WIDTH){1'b0}}, ram_rd_data};
    end
  endgenerate

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign count_m1 = count_r - CW'(1);

  // Entry memory.
  sws_stack_ram #(
    .DEPTH  (STACK_DEPTH),
    .WIDTH  (WORD_WIDTH),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (key_in),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer: decode the request, walk the memory for find, then hand the
  // result to the output register.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    key_nxt        = key_r;
    res_top_nxt    = res_top_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_top_nxt    = out_top_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    ram_wr_en      = 1'b0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = scan_idx_r - AW'(1);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt        = key_in;
          res_top_nxt    = '0;
          res_found_nxt  = 1'b0;
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
          case (action_t'(in_action))
            ACT_PUSH: begin
              if (count_r == CW'(STACK_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_wr_en = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            ACT_POP: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_m1;
              end
            end
            ACT_PEEK: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = count_m1[AW-1:0];
                state_nxt   = S_PEEK;
              end
            end
            ACT_FIND: begin
              if (count_r != '0) begin
                ram_rd_en    = 1'b1;
                ram_rd_addr  = count_m1[AW-1:0];
                scan_idx_nxt = count_m1[AW-1:0];
                state_nxt    = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_PEEK: begin
        res_top_nxt = rd_top;
        state_nxt   = S_RESP;
      end

      // One entry per cycle: compare the word just read and fetch the next.
      S_SCAN: begin
        if (ram_rd_data == key_r) begin
          res_found_nxt = 1'b1;
          state_nxt     = S_RESP;
        end else if (scan_idx_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          ram_rd_en    = 1'b1;
          scan_idx_nxt = scan_idx_r - AW'(1);
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_top_nxt    = res_top_r;
          out_found_nxt  = res_found_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    key_r        <= key_nxt;
    res_top_r    <= res_top_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_top_r    <= out_top_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_top_value = out_top_r;
  assign out_found     = out_found_r;
  assign out_status    = out_status_r;

endmodule
